[hw/rtl/rstc_pkg.sv]
// shared types, constants and opcode codes for the step target calculator
`default_nettype none
package rstc_pkg;

  localparam int DATA_W   = 64;
  localparam int INSN_W   = 32;
  localparam int XLEN_DEF = 64;
  localparam int REGS     = 32;
  localparam int REG_AW   = $clog2(REGS);

  // 32-bit opcodes
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_JAL    = 7'h6f;

  // instruction length / compressed quadrants
  localparam logic [1:0] QUAD_0  = 2'b00;
  localparam logic [1:0] QUAD_1  = 2'b01;
  localparam logic [1:0] QUAD_2  = 2'b10;
  localparam logic [1:0] QUAD_32 = 2'h3;

  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_RSV2 = 3'd2;
  localparam logic [2:0] F3_RSV3 = 3'd3;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // compressed funct3
  localparam logic [2:0] CF3_JAL  = 3'd1;
  localparam logic [2:0] CF3_JR   = 3'd4;
  localparam logic [2:0] CF3_J    = 3'd5;
  localparam logic [2:0] CF3_BEQZ = 3'd6;
  localparam logic [2:0] CF3_BNEZ = 3'd7;

  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [REG_AW-1:0] reg_index;
    logic [DATA_W-1:0] reg_value;
    logic [INSN_W-1:0] instruction;
    logic [DATA_W-1:0] pc;
  } rstc_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] next_pc;
    logic              jump_taken;
    logic              status;
  } rstc_out_t;

endpackage
`default_nettype wire

[hw/rtl/rstc_stream_if.sv]
// valid/ready channel carrying one item of type T
`default_nettype none
interface rstc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/rstc_ram.sv]
// generic ram, one write port, two registered read ports
`default_nettype none
module rstc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule
`default_nettype wire

[hw/rtl/rstc_next_pc.sv]
// decode, compare and target add for one instruction
`default_nettype none
module rstc_next_pc import rstc_pkg::*; (
  input  logic [INSN_W-1:0] ins,
  input  logic [DATA_W-1:0] pc,
  input  logic [DATA_W-1:0] rs1_raw,
  input  logic [DATA_W-1:0] rs2_raw,
  input  logic              narrow,
  output rstc_out_t         res
);

  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] sbit;
  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic              eq;
  logic              lt_s;
  logic              lt_u;
  logic [DATA_W-1:0] base;
  logic [DATA_W-1:0] off;
  logic [DATA_W-1:0] sum;
  logic              clr0;
  logic              taken;
  logic              status;
  logic [DATA_W-1:0] imm_b;
  logic [DATA_W-1:0] imm_j;
  logic [DATA_W-1:0] imm_i;
  logic [DATA_W-1:0] imm_cj;
  logic [DATA_W-1:0] imm_cb;
  logic              cond;

  assign mask = narrow ? DATA_W'(32'hffff_ffff) : '1;
  assign sbit = narrow ? DATA_W'(32'h8000_0000) : {1'b1, {(DATA_W-1){1'b0}}};
  assign a    = rs1_raw & mask;
  assign b    = rs2_raw & mask;
  assign eq   = (a == b);
  assign lt_s = ((a ^ sbit) < (b ^ sbit));
  assign lt_u = (a < b);

  assign imm_b  = {{52{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j  = {{44{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
  assign imm_i  = {{53{ins[31]}}, ins[30:20]};
  assign imm_cj = {{53{ins[12]}}, ins[8], ins[10:9], ins[6], ins[7], ins[2], ins[11],
                   ins[5:3], 1'b0};
  assign imm_cb = {{56{ins[12]}}, ins[6:5], ins[2], ins[11:10], ins[4:3], 1'b0};

  always_comb begin
    base   = pc;
    off    = (ins[1:0] == QUAD_32) ? DATA_W'(4) : DATA_W'(2);
    clr0   = 1'b0;
    taken  = 1'b0;
    status = 1'b0;
    cond   = 1'b0;
    unique case (ins[1:0])
      QUAD_32: begin
        unique case (ins[6:0])
          OP_BRANCH: begin
            unique case (ins[14:12])
              F3_BEQ:  cond = eq;
              F3_BNE:  cond = !eq;
              F3_BLT:  cond = lt_s;
              F3_BGE:  cond = !lt_s;
              F3_BLTU: cond = lt_u;
              F3_BGEU: cond = !lt_u;
              F3_RSV2, F3_RSV3: status = 1'b1;
              default: status = 1'b1;
            endcase
            if (cond) begin
              off   = imm_b;
              taken = 1'b1;
            end
          end
          OP_JALR: begin
            if (ins[14:12] == 3'd0) begin
              base  = a;
              off   = imm_i;
              clr0  = 1'b1;
              taken = 1'b1;
            end
          end
          OP_JAL: begin
            off   = imm_j;
            taken = 1'b1;
          end
          default: ;
        endcase
      end
      QUAD_1: begin
        if (ins[15:13] == CF3_J || (ins[15:13] == CF3_JAL && narrow)) begin
          off   = imm_cj;
          taken = 1'b1;
        end else if (ins[15:13] == CF3_BEQZ || ins[15:13] == CF3_BNEZ) begin
          cond = (ins[15:13] == CF3_BEQZ) ? (a == '0) : (a != '0);
          if (cond) begin
            off   = imm_cb;
            taken = 1'b1;
          end
        end
      end
      QUAD_2: begin
        if (ins[15:13] == CF3_JR && ins[6:2] == 5'd0 && ins[11:7] != 5'd0) begin
          base  = a;
          off   = '0;
          clr0  = 1'b1;
          taken = 1'b1;
        end
      end
      QUAD_0: ;
      default: ;
    endcase
  end

  assign sum = base + off;

  assign res.next_pc    = {sum[DATA_W-1:1], sum[0] & !clr0} & mask;
  assign res.jump_taken = taken;
  assign res.status     = status;

endmodule
`default_nettype wire

[hw/rtl/riscv_step_target_calc.sv]
// top level: register file, operand stage and result register of the step target calculator
// Takes one item per clock while results are taken. A write item (mode 0) stores into the
// 32-entry register file at its accept edge and produces no result. A compute item (mode 1)
// reads its two source registers from the registered-read register file at its accept edge
// into the operand stage; the next address is then decoded, compared and added into the
// result register when that stage can advance, and items can follow every cycle while
// results are taken. The input side keeps accepting while a result waits, as long as the
// operand stage is free. Register file contents after reset read as zero through per-entry
// valid bits; no clearing pass is needed.
// rv32_mode is written through the cfg channel, which is always ready.
`default_nettype none
module riscv_step_target_calc import rstc_pkg::*; #(
  parameter int XLEN = XLEN_DEF
) (
  input logic         clk,
  input logic         rst_n,
  rstc_stream_if.sink   in_if,
  rstc_stream_if.source out_if,
  rstc_stream_if.sink   cfg_if
);

  logic              rv32_mode_r;
  logic              narrow;
  logic              adv;
  logic              in_fire;
  logic              wr_en;
  logic              s1_load;
  logic [REG_AW-1:0] raddr_a;
  logic [REG_AW-1:0] raddr_b;
  logic [REGS-1:0]   vld_r;
  logic [XLEN-1:0]   rdata_a;
  logic [XLEN-1:0]   rdata_b;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [INSN_W-1:0] s1_ins_r;
  logic [DATA_W-1:0] s1_pc_r;
  logic              s1_ok_a_r;
  logic              s1_ok_b_r;
  logic [DATA_W-1:0] rs1_raw;
  logic [DATA_W-1:0] rs2_raw;

  rstc_out_t         res;
  logic              out_valid_r;
  logic              out_valid_nxt;
  rstc_out_t         out_data_r;

  // config
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv32_mode_r <= 1'b0;
    end else if (cfg_if.valid) begin
      rv32_mode_r <= cfg_if.data;
    end
  end

  assign narrow = rv32_mode_r || (XLEN <= 32);

  // handshake
  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = adv || !s1_valid_r;
  assign in_fire     = in_if.valid && in_if.ready;
  assign wr_en       = in_fire && (in_if.data.mode == MODE_WRITE);
  assign s1_load     = in_fire && (in_if.data.mode == MODE_COMPUTE);

  // source register select
  always_comb begin
    if (in_if.data.instruction[1:0] == QUAD_32) begin
      raddr_a = in_if.data.instruction[19:15];
    end else if (in_if.data.instruction[1:0] == QUAD_1) begin
      raddr_a = {2'b01, in_if.data.instruction[9:7]};
    end else begin
      raddr_a = in_if.data.instruction[11:7];
    end
  end
  assign raddr_b = in_if.data.instruction[24:20];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[in_if.data.reg_index] <= 1'b1;
    end
  end

  rstc_ram #(
    .WIDTH (XLEN),
    .DEPTH (REGS)
  ) u_regfile (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (in_if.data.reg_index),
    .wdata   (in_if.data.reg_value[XLEN-1:0]),
    .re      (s1_load),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // operand stage
  assign s1_valid_nxt = s1_load ? 1'b1 : (adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_ins_r  <= in_if.data.instruction;
      s1_pc_r   <= in_if.data.pc;
      s1_ok_a_r <= vld_r[raddr_a] && (raddr_a != '0);
      s1_ok_b_r <= vld_r[raddr_b] && (raddr_b != '0);
    end
  end

  assign rs1_raw = s1_ok_a_r ? DATA_W'(rdata_a) : '0;
  assign rs2_raw = s1_ok_b_r ? DATA_W'(rdata_b) : '0;

  rstc_next_pc u_next_pc (
    .ins     (s1_ins_r),
    .pc      (s1_pc_r),
    .rs1_raw (rs1_raw),
    .rs2_raw (rs2_raw),
    .narrow  (narrow),
    .res     (res)
  );

  // result register
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_data_r <= res;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

`ifndef ASSERT_OFF
  a_wr_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(in_if.data.reg_index)])
    else $error("register write did not mark entry valid");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_ins_r) && $stable(s1_pc_r)))
    else $error("operand stage lost a stalled item");

  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv) |=> out_valid_r)
    else $error("operand stage item did not reach result register");

  a_status_no_jump: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status) |-> !out_data_r.jump_taken)
    else $error("reserved branch reported as taken");
`endif

endmodule
`default_nettype wire
